// ===== hdl/bs_pkg.sv =====
// Shared types and constants for the batch sorter.
package bs_pkg;

  localparam int VALUE_W          = 32;
  localparam int MAX_ITEMS_DEF    = 64;
  localparam int DATA_WIDTH_DEF   = 32;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               end_of_batch;
    logic               dropped;
  } result_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_cmd_t;

  // Status a cell hands to its right-hand neighbour.
  typedef struct packed {
    logic occ;
    logic takes;
  } link_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// ===== hdl/bs_cell.sv =====
// One slot of the insertion chain: holds a value and its occupied flag.
module bs_cell #(
  parameter int DATA_WIDTH = bs_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bs_pkg::cell_cmd_t     cmd,
  input  logic [DATA_WIDTH-1:0] ins_value,
  input  bs_pkg::link_t         prev_link,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic                  next_occ,
  input  logic [DATA_WIDTH-1:0] next_data,
  output bs_pkg::link_t         link,
  output logic [DATA_WIDTH-1:0] data
);

  logic occ;

  // An empty slot, or one holding a larger value, gets displaced.
  assign link.occ   = occ;
  assign link.takes = !occ || (data > ins_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (cmd.insert) begin
      if (link.takes) begin
        occ <= occ | prev_link.occ;
      end
    end else if (cmd.shift) begin
      occ <= next_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (link.takes) begin
        data <= prev_link.takes ? prev_data : ins_value;
      end
    end else if (cmd.shift) begin
      data <= next_data;
    end
  end

endmodule

// ===== hdl/batch_sorter.sv =====
// Batch sorter top level: insertion chain of cells plus fill/drain control.
//
// Input channel (item_valid / item_stall / item): one value per beat, item.last
// closes the batch. Values are inserted into a sorted chain of MAX_ITEMS cells,
// one beat per cycle. Once the store holds MAX_ITEMS values further beats
// are discarded and the dropped flag is raised for every result of that batch.
// The cycle after the last beat, the chain drains from its low end on the
// result channel (result_valid / result_stall / result), smallest value first,
// one result per cycle while result_stall is low; end_of_batch marks the final
// one. item_stall is high for the whole drain; the first beat of the next batch is
// taken the cycle after the final result is accepted.
// A stalled result holds: the chain does not shift until the beat is taken.
// Reset (rst, synchronous) empties the chain, clears the drop flag and
// returns to loading.
module batch_sorter #(
  parameter int MAX_ITEMS  = bs_pkg::MAX_ITEMS_DEF,
  parameter int DATA_WIDTH = bs_pkg::DATA_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  bs_pkg::item_t   item,
  output logic            result_valid,
  input  logic            result_stall,
  output bs_pkg::result_t result
);

  bs_pkg::state_t    state, state_next;
  logic              overflow, overflow_next;
  bs_pkg::cell_cmd_t cmd;
  logic [DATA_WIDTH-1:0] ins_value;
  logic [DATA_WIDTH-1:0] cell_data [MAX_ITEMS];
  bs_pkg::link_t         cell_link [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]  occ;
  logic item_acc, result_acc, full;

  if (DATA_WIDTH <= bs_pkg::VALUE_W) begin : g_in_narrow
    assign ins_value = item.value[DATA_WIDTH-1:0];
  end else begin : g_in_wide
    assign ins_value = {{(DATA_WIDTH-bs_pkg::VALUE_W){1'b0}}, item.value};
  end

  if (DATA_WIDTH >= bs_pkg::VALUE_W) begin : g_out_wide
    assign result.sorted_value = cell_data[0][bs_pkg::VALUE_W-1:0];
  end else begin : g_out_narrow
    assign result.sorted_value = {{(bs_pkg::VALUE_W-DATA_WIDTH){1'b0}}, cell_data[0]};
  end

  assign item_stall  = (state != bs_pkg::ST_FILL);
  assign item_acc    = item_valid && !item_stall;
  assign result_valid = (state == bs_pkg::ST_DRAIN);
  assign result_acc  = result_valid && !result_stall;
  assign full        = occ[MAX_ITEMS-1];

  assign result.end_of_batch = !occ[1];
  assign result.dropped      = overflow;

  assign cmd.insert = item_acc && !full;
  assign cmd.shift  = result_acc;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    bs_pkg::link_t         prev_link;
    logic [DATA_WIDTH-1:0] prev_data;
    logic                  next_occ;
    logic [DATA_WIDTH-1:0] next_data;

    if (i == 0) begin : g_head
      // Head cell: nothing to its left, so when it takes, it loads the new value.
      assign prev_link = '{occ: 1'b1, takes: 1'b0};
      assign prev_data = '0;
    end else begin : g_body
      assign prev_link = cell_link[i-1];
      assign prev_data = cell_data[i-1];
    end

    if (i == MAX_ITEMS-1) begin : g_tail
      assign next_occ  = 1'b0;
      assign next_data = '0;
    end else begin : g_mid
      assign next_occ  = cell_link[i+1].occ;
      assign next_data = cell_data[i+1];
    end

    bs_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .ins_value(ins_value),
      .prev_link(prev_link),
      .prev_data(prev_data),
      .next_occ (next_occ),
      .next_data(next_data),
      .link     (cell_link[i]),
      .data     (cell_data[i])
    );

    assign occ[i] = cell_link[i].occ;
  end

  always_comb begin
    state_next    = state;
    overflow_next = overflow;
    unique case (state)
      bs_pkg::ST_FILL: begin
        if (item_acc) begin
          overflow_next = overflow | full;
          if (item.last) begin
            state_next = bs_pkg::ST_DRAIN;
          end
        end
      end
      bs_pkg::ST_DRAIN: begin
        if (result_acc && result.end_of_batch) begin
          state_next    = bs_pkg::ST_FILL;
          overflow_next = 1'b0;
        end
      end
      default: begin
        state_next    = bs_pkg::ST_FILL;
        overflow_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bs_pkg::ST_FILL;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      overflow <= overflow_next;
    end
  end

  // Draining never runs on an empty chain.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> occ[0])
    else $error("drain with empty chain");

  // Occupied cells stay packed at the low end.
  a_occ_packed: assert property (@(posedge clk) disable iff (rst)
    ((occ >> 1) & ~occ) == '0)
    else $error("hole in occupied cells");

  // A stored beat grows the chain by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (item_acc && !full) |=> ($countones(occ) == $past($countones(occ)) + 1))
    else $error("insert did not add one entry");

  // After the final result the chain is empty and the drop flag clear.
  a_batch_close: assert property (@(posedge clk) disable iff (rst)
    (result_acc && result.end_of_batch) |=> (occ == '0 && !overflow && !result_valid))
    else $error("batch not closed cleanly");

endmodule
